FILE: rtl/core/cpbm_pkg.sv
// Package for the clock page buffer manager core: sizes, opcodes, status codes.
// No dependencies.
package cpbm_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int FW = $clog2(NUM_FRAMES);
    localparam logic [7:0] PIN_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ = 2'd0, OP_ALLOC = 2'd1, OP_UNPIN = 2'd2, OP_DISPOSE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EXCEEDED = 2'd1, ST_PINNED = 2'd2, ST_NOT_PINNED = 2'd3
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [7:0]  file;
        logic [31:0] page;
        logic [7:0]  pin;
        logic        refb;
        logic        dirty;
    } t_entry;
endpackage

FILE: rtl/core/cpbm_table.sv
// Frame table memory: one synchronous read port, one write port.
// Depends on cpbm_pkg. Valid bits live in flip-flops so reset clears them at once.
module cpbm_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [cpbm_pkg::FW-1:0] i_raddr,
    output cpbm_pkg::t_entry     o_rdata,
    input  logic                 i_we,
    input  logic [cpbm_pkg::FW-1:0] i_waddr,
    input  cpbm_pkg::t_entry     i_wdata
);
    import cpbm_pkg::*;
    t_entry mem [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] r_vld;
    t_entry r_rd;
    logic   r_rv;
    logic [FW-1:0] r_ra;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        r_rd <= mem[i_raddr];
        r_ra <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= i_wdata.valid;
        end
    end

    assign r_rv = r_vld[r_ra];
    always_comb begin
        o_rdata = r_rd;
        if (!r_rv) begin
            o_rdata.valid = 1'b0;
            o_rdata.pin   = '0;
            o_rdata.refb  = 1'b0;
            o_rdata.dirty = 1'b0;
        end
    end
endmodule

FILE: rtl/core/clock_page_buffer_manager_core.sv
// Clock page buffer manager core: frame table with clock replacement.
// The lookup streams every frame through the table read port (S_SCAN), then the decide
// state (S_DEC) follows; a sweep adds up to 2*NUM_FRAMES frames, each read, then written back.
// Result strobe o_done comes in S_DONE; busy drops the cycle after it, so the core handles
// one request at a time.
// Reset (synchronous, active low) clears all frames and sets the hand to NUM_FRAMES-1.
// The result is shown for one cycle on o_done; the receiver cannot stall.
module clock_page_buffer_manager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_file_id,
    input  logic [31:0] i_page_number,
    input  logic        i_mark_dirty,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_frame,
    output logic        o_resident,
    output logic        o_fetch_needed,
    output logic        o_evict_writeback,
    output logic [7:0]  o_evict_file,
    output logic [31:0] o_evict_page
);
    import cpbm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001, S_SCAN = 6'b000010, S_DEC  = 6'b000100,
        S_SWRD  = 6'b001000, S_SWCHK = 6'b010000, S_DONE = 6'b100000
    } t_state;

    localparam int CW = $clog2(2 * NUM_FRAMES + 1);

    t_state r_state, n_state;
    logic [FW-1:0] r_hand, n_hand, r_idx, n_idx;
    logic [FW:0]   r_cnt, n_cnt;       // lookup read counter
    logic [CW-1:0] r_sw, n_sw;         // sweep step counter
    logic r_hit, n_hit;
    logic [FW-1:0] r_hidx, n_hidx;
    t_entry r_hent, n_hent;
    logic [1:0] r_op;
    logic [7:0] r_f;
    logic [31:0] r_p;
    logic r_md;

    logic [FW-1:0] raddr;
    t_entry rdata, wdata;
    logic we;
    logic [FW-1:0] waddr;

    logic [1:0] n_st, r_st;
    logic [3:0] n_fr, r_fr;
    logic n_res, r_res, n_fet, r_fet, n_wb, r_wb;
    logic [7:0] n_ef, r_ef;
    logic [31:0] n_ep, r_ep;

    cpbm_table u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_raddr(raddr), .o_rdata(rdata),
        .i_we(we), .i_waddr(waddr), .i_wdata(wdata)
    );

    assign busy = (r_state != S_IDLE);

    function automatic logic [FW-1:0] nxt(input logic [FW-1:0] h);
        logic [FW-1:0] r;
        if (h == FW'(NUM_FRAMES - 1)) r = '0;
        else r = h + 1'b1;
        return r;
    endfunction

    always_comb begin
        t_entry fresh;
        n_state = r_state; n_hand = r_hand; n_idx = r_idx; n_cnt = r_cnt;
        n_sw = r_sw; n_hit = r_hit; n_hidx = r_hidx; n_hent = r_hent;
        n_st = r_st; n_fr = r_fr; n_res = r_res; n_fet = r_fet; n_wb = r_wb;
        n_ef = r_ef; n_ep = r_ep;
        raddr = r_idx; we = 1'b0; waddr = r_idx; wdata = rdata;
        fresh.valid = 1'b1; fresh.file = r_f; fresh.page = r_p;
        fresh.pin = 8'd1; fresh.refb = 1'b1; fresh.dirty = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN; n_idx = '0; n_cnt = '0; n_hit = 1'b0;
                    n_st = ST_OK; n_fr = '0; n_res = 1'b0; n_fet = 1'b0;
                    n_wb = 1'b0; n_ef = '0; n_ep = '0;
                end
            end
            S_SCAN: begin
                // issue read of r_idx; check data of the previous read
                raddr = r_idx;
                if (r_cnt != '0 && !r_hit && rdata.valid && rdata.file == r_f
                    && rdata.page == r_p) begin
                    n_hit = 1'b1; n_hidx = FW'(r_cnt - 1'b1); n_hent = rdata;
                end
                n_cnt = r_cnt + 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_cnt == (FW+1)'(NUM_FRAMES)) n_state = S_DEC;
            end
            S_DEC: begin
                if (r_op == OP_READ && r_hit) begin
                    we = 1'b1; waddr = r_hidx; wdata = r_hent; wdata.refb = 1'b1;
                    if (r_hent.pin != PIN_MAX) wdata.pin = r_hent.pin + 1'b1;
                    n_fr = 4'(r_hidx); n_res = 1'b1; n_state = S_DONE;
                end else if (r_op == OP_READ || r_op == OP_ALLOC) begin
                    n_sw = '0; n_hand = nxt(r_hand); n_state = S_SWRD;
                end else begin
                    n_state = S_DONE;
                    if (r_hit) begin
                        n_fr = 4'(r_hidx); n_res = 1'b1; waddr = r_hidx;
                        wdata = r_hent;
                        if (r_op == OP_UNPIN) begin
                            if (r_hent.pin == '0) n_st = ST_NOT_PINNED;
                            else begin
                                we = 1'b1; wdata.pin = r_hent.pin - 1'b1;
                                if (r_md) wdata.dirty = 1'b1;
                            end
                        end else if (r_hent.pin != '0) begin
                            n_st = ST_PINNED;
                        end else begin
                            we = 1'b1; wdata.valid = 1'b0; wdata.refb = 1'b0;
                            wdata.dirty = 1'b0;
                        end
                    end
                end
            end
            S_SWRD: begin
                raddr = r_hand; n_state = S_SWCHK;
            end
            S_SWCHK: begin
                waddr = r_hand;
                if (!rdata.valid || (!rdata.refb && rdata.pin == '0)) begin
                    if (rdata.valid && rdata.dirty) begin
                        n_wb = 1'b1; n_ef = rdata.file; n_ep = rdata.page;
                    end
                    we = 1'b1; wdata = fresh; n_fr = 4'(r_hand);
                    n_fet = (r_op == OP_READ); n_state = S_DONE;
                end else begin
                    if (rdata.refb) begin
                        we = 1'b1; wdata = rdata; wdata.refb = 1'b0;
                    end
                    if (r_sw == CW'(2 * NUM_FRAMES - 1)) begin
                        n_st = ST_EXCEEDED; n_state = S_DONE;
                    end else begin
                        n_sw = r_sw + 1'b1; n_hand = nxt(r_hand); n_state = S_SWRD;
                    end
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hand  <= FW'(NUM_FRAMES - 1);
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
        end
    end

    always_ff @(posedge i_clk) begin
        // hold the request beat while busy
        if (r_state == S_IDLE && start) begin
            r_op <= i_operation; r_f <= i_file_id; r_p <= i_page_number;
            r_md <= i_mark_dirty;
        end
        r_idx <= n_idx; r_cnt <= n_cnt; r_sw <= n_sw; r_hit <= n_hit;
        r_hidx <= n_hidx; r_hent <= n_hent;
        r_st <= n_st; r_fr <= n_fr; r_res <= n_res; r_fet <= n_fet;
        r_wb <= n_wb; r_ef <= n_ef; r_ep <= n_ep;
    end

    assign o_done = (r_state == S_DONE);
    assign o_status = r_st;
    assign o_frame = r_fr;
    assign o_resident = r_res;
    assign o_fetch_needed = r_fet;
    assign o_evict_writeback = r_wb;
    assign o_evict_file = r_ef;
    assign o_evict_page = r_ep;
endmodule

FILE: rtl/core/cpbm_checker.sv
// Port-level checks for the clock page buffer manager core.
// Depends on cpbm_pkg; bound to clock_page_buffer_manager_core.
module cpbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [3:0]  o_frame,
    input logic        o_resident,
    input logic        o_fetch_needed,
    input logic        o_evict_writeback
);
    import cpbm_pkg::*;
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat outside a request");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy held after result");
    a_exceeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EXCEEDED) |-> (o_frame == '0 && !o_resident
        && !o_fetch_needed && !o_evict_writeback)) else $error("exceeded not clean");
endmodule

bind clock_page_buffer_manager_core cpbm_checker u_cpbm_checker (.*);

FILE: test/clock_page_buffer_manager_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the clock page buffer manager core: frame lookup,
// clock sweep, pin/unpin, dispose and writeback victims. Depends on cpbm_pkg.
module clock_page_buffer_manager_core_test;
    import cpbm_pkg::*;

    typedef struct packed {
        t_op         op;
        logic [7:0]  file;
        logic [31:0] page;
        logic        dirty;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [3:0]  frame;
        logic        resident;
        logic        fetch;
        logic        wb;
        logic [7:0]  efile;
        logic [31:0] epage;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_file_id;
    logic [31:0] i_page_number;
    logic        i_mark_dirty;
    logic        o_done;
    logic [1:0]  o_status;
    logic [3:0]  o_frame;
    logic        o_resident;
    logic        o_fetch_needed;
    logic        o_evict_writeback;
    logic [7:0]  o_evict_file;
    logic [31:0] o_evict_page;

    clock_page_buffer_manager_core u_top (.*);

    // Shadow frame table
    logic        tbl_valid [NUM_FRAMES];
    logic [7:0]  tbl_file  [NUM_FRAMES];
    logic [31:0] tbl_page  [NUM_FRAMES];
    logic [7:0]  tbl_pin   [NUM_FRAMES];
    logic        tbl_ref   [NUM_FRAMES];
    logic        tbl_dirty [NUM_FRAMES];
    int          hand;

    t_request pending_q[$];
    t_answer  answer_q[$];
    int       errors = 0;
    int       beats_in = 0;
    int       beats_out = 0;
    int       evictions = 0;
    int       exceeded = 0;
    int       idle_pct = 18;
    int       stall_count = 0;
    bit       feed_done = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Advance the shadow table by one request and return the answer it implies.
    function automatic t_answer predict_frame_table(t_request r);
        t_answer a;
        int hit;
        int claim;
        int h;
        a = '0;
        hit = -1;
        claim = -1;
        for (int k = NUM_FRAMES - 1; k >= 0; k--)
            if (tbl_valid[k] && tbl_file[k] == r.file && tbl_page[k] == r.page) hit = k;
        if (r.op == OP_READ && hit >= 0) begin
            tbl_ref[hit] = 1;
            if (tbl_pin[hit] != PIN_MAX) tbl_pin[hit]++;
            a.frame = 4'(hit);
            a.resident = 1;
        end else if (r.op == OP_READ || r.op == OP_ALLOC) begin
            // Sweep the clock: up to two full turns
            for (int n = 0; n < 2 * NUM_FRAMES && claim < 0; n++) begin
                h = (hand + 1) % NUM_FRAMES;
                hand = h;
                if (!tbl_valid[h]) claim = h;
                else if (tbl_ref[h]) tbl_ref[h] = 0;
                else if (tbl_pin[h] == 0) begin
                    claim = h;
                    if (tbl_dirty[h]) begin
                        a.wb = 1;
                        a.efile = tbl_file[h];
                        a.epage = tbl_page[h];
                    end
                end
            end
            if (claim < 0) begin
                a.status = ST_EXCEEDED;
            end else begin
                tbl_valid[claim] = 1;
                tbl_file[claim] = r.file;
                tbl_page[claim] = r.page;
                tbl_pin[claim] = 1;
                tbl_ref[claim] = 1;
                tbl_dirty[claim] = 0;
                a.frame = 4'(claim);
                a.fetch = (r.op == OP_READ);
            end
        end else if (hit >= 0) begin
            a.frame = 4'(hit);
            a.resident = 1;
            if (r.op == OP_UNPIN) begin
                if (tbl_pin[hit] == 0) a.status = ST_NOT_PINNED;
                else begin
                    tbl_pin[hit]--;
                    if (r.dirty) tbl_dirty[hit] = 1;
                end
            end else if (tbl_pin[hit] != 0) begin
                a.status = ST_PINNED;
            end else begin
                tbl_valid[hit] = 0;
                tbl_ref[hit] = 0;
                tbl_dirty[hit] = 0;
                tbl_pin[hit] = 0;
            end
        end
        return a;
    endfunction

    function automatic t_request make_req(t_op op, logic [7:0] f, logic [31:0] p, logic d);
        t_request r;
        r.op = op;
        r.file = f;
        r.page = p;
        r.dirty = d;
        return r;
    endfunction

    // Pick from a small pool of pages so hits, duplicates and evictions happen often;
    // now and then use a fully random page to exercise every address bit.
    function automatic t_request rand_req();
        logic [7:0]  f;
        logic [31:0] p;
        int sel;
        t_op op;
        sel = $urandom_range(0, 99);
        if (sel < 45) op = OP_READ;
        else if (sel < 55) op = OP_ALLOC;
        else if (sel < 88) op = OP_UNPIN;
        else op = OP_DISPOSE;
        if ($urandom_range(0, 9) == 0) begin
            f = 8'($urandom);
            p = $urandom;
        end else begin
            f = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(0, 2));
            p = $urandom_range(0, 7) == 0 ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                          : $urandom_range(0, 23);
        end
        return make_req(op, f, p, 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        for (int k = 0; k < NUM_FRAMES; k++) begin
            tbl_valid[k] = 0;
            tbl_file[k] = '0;
            tbl_page[k] = '0;
            tbl_pin[k] = '0;
            tbl_ref[k] = 0;
            tbl_dirty[k] = 0;
        end
        hand = NUM_FRAMES - 1;

        // Directed: misses on an empty pool, unpin/dispose of absent pages
        pending_q.push_back(make_req(OP_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1));
        pending_q.push_back(make_req(OP_DISPOSE, 8'h00, 32'h0, 0));
        pending_q.push_back(make_req(OP_READ, 8'h00, 32'h0, 0));
        pending_q.push_back(make_req(OP_READ, 8'hFF, 32'hFFFF_FFFF, 1));
        // Hit, then unpin three times (the third one finds the page unpinned)
        pending_q.push_back(make_req(OP_READ, 8'h00, 32'h0, 0));
        pending_q.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 1));
        pending_q.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 0));
        pending_q.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 0));
        // Dispose of a pinned page, then of an unpinned one
        pending_q.push_back(make_req(OP_DISPOSE, 8'hFF, 32'hFFFF_FFFF, 0));
        pending_q.push_back(make_req(OP_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1));
        pending_q.push_back(make_req(OP_DISPOSE, 8'hFF, 32'hFFFF_FFFF, 0));
        // Allocate a duplicate of a resident page
        pending_q.push_back(make_req(OP_ALLOC, 8'h00, 32'h0, 0));
        // Fill and pin every frame, then overflow the pool
        for (int k = 0; k < NUM_FRAMES; k++)
            pending_q.push_back(make_req(OP_ALLOC, 8'hA5, 32'h5A00 + k, 0));
        pending_q.push_back(make_req(OP_READ, 8'h5A, 32'h1234_5678, 0));
        // Saturate a pin count
        for (int k = 0; k < 260; k++)
            pending_q.push_back(make_req(OP_READ, 8'hA5, 32'h5A00, 0));
        // Unpin the filled pages once each so the random part starts with a live pool
        for (int k = 0; k < NUM_FRAMES; k++)
            pending_q.push_back(make_req(OP_UNPIN, 8'hA5, 32'h5A00 + k, k[0]));
        pending_q.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 1));
        pending_q.push_back(make_req(OP_UNPIN, 8'h00, 32'h0, 1));
        for (int k = 0; k < 1700; k++) pending_q.push_back(rand_req());
        feed_done = 1;
    end

    // Reset and drive: hold start while an item waits, drop it on acceptance.
    initial begin
        i_rst_n = 0;
        start = 0;
        i_operation = '0;
        i_file_id = '0;
        i_page_number = '0;
        i_mark_dirty = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && feed_done) begin
            // A stretch with no idling in the middle of the run
            idle_pct <= (beats_in > 800 && beats_in < 1300) ? 0 : 18;
            if (start && !busy) begin
                t_request r;
                r = make_req(t_op'(i_operation), i_file_id, i_page_number, i_mark_dirty);
                answer_q.push_back(predict_frame_table(r));
                beats_in <= beats_in + 1;
            end
            if ((!start || !busy) && pending_q.size() > 0 &&
                $urandom_range(0, 99) >= idle_pct) begin
                t_request n;
                n = pending_q.pop_front();
                start <= 1;
                i_operation <= n.op;
                i_file_id <= n.file;
                i_page_number <= n.page;
                i_mark_dirty <= n.dirty;
            end else if (!busy) begin
                start <= 0;
            end
        end
    end

    // Compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_answer got, want;
            got = {t_status'(o_status), o_frame, o_resident, o_fetch_needed,
                   o_evict_writeback, o_evict_file, o_evict_page};
            beats_out <= beats_out + 1;
            if (answer_q.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = answer_q.pop_front();
                if (got.wb) evictions <= evictions + 1;
                if (got.status == ST_EXCEEDED) exceeded <= exceeded + 1;
                if (got !== want) begin
                    $display("%0t: mismatch expected st=%0d fr=%0d res=%b fetch=%b wb=%b ef=%h ep=%h",
                             $time, want.status, want.frame, want.resident, want.fetch,
                             want.wb, want.efile, want.epage);
                    $display("%0t:          actual   st=%0d fr=%0d res=%b fetch=%b wb=%b ef=%h ep=%h",
                             $time, got.status, got.frame, got.resident, got.fetch,
                             got.wb, got.efile, got.epage);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat in either direction.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count > 2000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        wait (feed_done);
        wait (pending_q.size() == 0 && !start && answer_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d requests, %0d results, %0d dirty evictions, %0d exhausted pools.",
                 beats_in, beats_out, evictions, exceeded);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/cpbm_pkg.sv
rtl/core/cpbm_table.sv
rtl/core/clock_page_buffer_manager_core.sv
rtl/core/cpbm_checker.sv
test/clock_page_buffer_manager_core_test.sv
